### sv/bprlz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprlz_pkg
// Shared types and constants of the paired back-reference LZ decoder.
// ----------------------------------------------------------------------------
package bprlz_pkg;

    localparam int POS_W         = 17;
    localparam int HISTORY_DEPTH_DEF = 256;
    localparam int TDATA_IN_W    = 8;
    localparam int TDATA_OUT_W   = 32;
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 32;

    localparam logic [POS_W-1:0] POS_MAX   = '1;
    localparam logic [POS_W-1:0] CAP_RESET = '1;

    // register indexes (word address)
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_CAP   = 2'd2;
    localparam logic [1:0] REG_BIAS  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_BYTE   = 2'd0;
    localparam logic [1:0] ST_FINISH = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [7:0] CTRL_REF   = 8'h80;
    localparam logic [3:0] LEN_BIAS   = 4'd2;

    typedef struct packed {
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] end_pos;
        logic [POS_W-1:0] cap_limit;
        logic             bias_en;
    } t_cfg;

    typedef struct packed {
        logic we;
        logic re;
    } t_hist_ctl;

endpackage

### sv/paired_backref_lz_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paired_backref_lz_decoder_unit
// Byte-oriented LZ77 first-stage decoder with paired back references and a
// 256-byte history ring that persists across runs.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] data_byte, tuser first_byte, tlast final_byte
// m_axis    out  tdata out_byte/status/consumed_count, tlast last_of_run
// apb       in   start_position, end_position, capacity_limit, bias_enable
//
// A source byte is registered in S_IDLE and decoded in the next cycle, in
// S_DEC. A literal then passes S_LIT and S_POST; a first-of-pair control
// byte returns to S_IDLE; a back reference passes S_CHK, one S_RD/S_WR
// history read/write pair per copied byte, and S_POST. A finish or error
// result adds S_EMIT. Output stalls hold the sequencer at its next result.
// Reset clears control state and the history valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module paired_backref_lz_decoder_unit #(
    parameter int HISTORY_DEPTH = bprlz_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [bprlz_pkg::TDATA_IN_W-1:0]  i_s_tdata,  // [7:0] data_byte
    input  logic                              i_s_tuser,  // first_byte
    input  logic                              i_s_tlast,  // final_byte
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [7:0] out_byte, [9:8] status, [26:10] consumed_count, [31:27] zero
    output logic [bprlz_pkg::TDATA_OUT_W-1:0] o_m_tdata,
    output logic                              o_m_tlast,  // last_of_run
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [bprlz_pkg::APB_AW-1:0]      i_paddr,
    input  logic [bprlz_pkg::APB_DW-1:0]      i_pwdata,
    output logic [bprlz_pkg::APB_DW-1:0]      o_prdata,
    output logic                              o_pready
);
    import bprlz_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    t_cfg          cfg;
    t_hist_ctl     hctl;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    wdata;
    logic [7:0]    rdata;

    bprlz_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    bprlz_hist #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bprlz_core #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_data     (i_s_tdata),
        .i_first    (i_s_tuser),
        .i_final    (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_hctl     (hctl),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

endmodule

### sv/bprlz_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprlz_regs
// APB register bank: run start, run end, capacity limit and literal bias.
// ----------------------------------------------------------------------------
module bprlz_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [bprlz_pkg::APB_AW-1:0] i_paddr,
    input  logic [bprlz_pkg::APB_DW-1:0] i_pwdata,
    output logic [bprlz_pkg::APB_DW-1:0] o_prdata,
    output logic                       o_pready,
    output bprlz_pkg::t_cfg            o_cfg
);
    import bprlz_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign reg_idx  = i_paddr[3:2];
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_pos <= '0;
            r_cfg.end_pos   <= '0;
            r_cfg.cap_limit <= CAP_RESET;
            r_cfg.bias_en   <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START: r_cfg.start_pos <= i_pwdata[POS_W-1:0];
                REG_END:   r_cfg.end_pos   <= i_pwdata[POS_W-1:0];
                REG_CAP:   r_cfg.cap_limit <= i_pwdata[POS_W-1:0];
                REG_BIAS:  r_cfg.bias_en   <= i_pwdata[0];
                default:   r_cfg.bias_en   <= r_cfg.bias_en;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (reg_idx)
            REG_START: o_prdata[POS_W-1:0] = r_cfg.start_pos;
            REG_END:   o_prdata[POS_W-1:0] = r_cfg.end_pos;
            REG_CAP:   o_prdata[POS_W-1:0] = r_cfg.cap_limit;
            REG_BIAS:  o_prdata[0]         = r_cfg.bias_en;
            default:   o_prdata            = '0;
        endcase
    end

endmodule

### sv/bprlz_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprlz_hist
// History ring: one write and one registered read per cycle. Per-entry valid
// bits make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module bprlz_hist #(
    parameter int HISTORY_DEPTH = bprlz_pkg::HISTORY_DEPTH_DEF,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bprlz_pkg::t_hist_ctl i_ctl,
    input  logic [AW-1:0]        i_waddr,
    input  logic [7:0]           i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [7:0]           o_rdata
);
    import bprlz_pkg::*;

    logic [7:0]               r_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_valid;
    logic [7:0]               r_rdata;
    logic                     r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_ctl.we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_ctl.re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : 8'h00;

endmodule

### sv/bprlz_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bprlz_core
// Decode sequencer: parses control/extras bytes, walks back-reference copies
// one byte per read/write pair, and drives the result register.
// ----------------------------------------------------------------------------
module bprlz_core #(
    parameter int HISTORY_DEPTH = bprlz_pkg::HISTORY_DEPTH_DEF,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bprlz_pkg::t_cfg         i_cfg,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [7:0]              i_data,
    input  logic                    i_first,
    input  logic                    i_final,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [bprlz_pkg::TDATA_OUT_W-1:0] o_m_tdata,
    output logic                    o_m_tlast,
    output bprlz_pkg::t_hist_ctl    o_hctl,
    output logic [AW-1:0]           o_waddr,
    output logic [7:0]              o_wdata,
    output logic [AW-1:0]           o_raddr,
    input  logic [7:0]              i_rdata
);
    import bprlz_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_CHK, S_RD, S_WR, S_LIT, S_POST, S_EMIT
    } t_state;

    t_state           r_state;
    logic [7:0]       r_data;
    logic             r_fin;
    logic             r_run;
    logic             r_await;
    logic             r_pair;
    logic [7:0]       r_hctrl;
    logic [7:0]       r_hext;
    logic [POS_W-1:0] r_wp;
    logic [POS_W-1:0] r_sc;
    logic [8:0]       r_dist;
    logic [3:0]       r_cnt;
    logic [AW-1:0]    r_src;
    logic [7:0]       r_lit;
    logic [1:0]       r_pst;
    logic [POS_W-1:0] r_pcnt;
    logic             r_ovalid;
    logic [TDATA_OUT_W-1:0] r_odata;
    logic             r_olast;

    logic             can_emit;
    logic             emit_fire;
    logic [POS_W-1:0] wp_inc;
    logic [POS_W-1:0] sc_inc;
    logic             end_after;
    logic [7:0]       wr_byte;
    logic [7:0]       lit_val;

    assign can_emit  = !r_ovalid || i_m_tready;
    // a new result is loaded into the output register this cycle
    assign emit_fire = can_emit &&
                       ((r_state == S_WR) || (r_state == S_LIT) || (r_state == S_EMIT));
    assign wp_inc    = r_wp + POS_W'(1);
    assign sc_inc    = (r_sc == POS_MAX) ? r_sc : r_sc + POS_W'(1);
    assign end_after = wp_inc >= i_cfg.end_pos;
    assign lit_val   = (r_data != 8'h00 && i_cfg.bias_en) ? {1'b1, r_data[6:0]} : r_data;
    assign wr_byte   = (r_state == S_WR) ? i_rdata : r_lit;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

    assign o_hctl.we = ((r_state == S_WR) || (r_state == S_LIT)) && can_emit;
    assign o_hctl.re = (r_state == S_RD);
    assign o_waddr   = r_wp[AW-1:0];
    assign o_wdata   = wr_byte;
    assign o_raddr   = r_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_run    <= 1'b0;
            r_await  <= 1'b0;
            r_pair   <= 1'b0;
            r_hctrl  <= '0;
            r_hext   <= '0;
            r_wp     <= '0;
            r_sc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_m_tready && !emit_fire) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_data <= i_data;
                        r_fin  <= i_final;
                        if (i_first) begin
                            r_wp    <= i_cfg.start_pos;
                            r_sc    <= '0;
                            r_pair  <= 1'b0;
                            r_await <= 1'b0;
                            r_run   <= 1'b1;
                        end
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (!r_run) begin
                        r_state <= S_IDLE;
                    end else if (r_await) begin
                        r_hext  <= r_data;
                        r_sc    <= sc_inc;
                        r_await <= 1'b0;
                        r_pair  <= 1'b1;
                        r_dist  <= {1'b0, r_hctrl[6:0], r_data[4]} + 9'd1;
                        r_cnt   <= {1'b0, r_data[7:5]} + LEN_BIAS;
                        r_state <= S_CHK;
                    end else if (r_wp >= i_cfg.end_pos) begin
                        r_pst   <= ST_FINISH;
                        r_pcnt  <= r_sc;
                        r_run   <= 1'b0;
                        r_state <= S_EMIT;
                    end else if (r_wp >= i_cfg.cap_limit) begin
                        r_pst   <= ST_ERROR;
                        r_run   <= 1'b0;
                        r_state <= S_EMIT;
                    end else if (r_data < CTRL_REF) begin
                        r_lit   <= lit_val;
                        r_sc    <= sc_inc;
                        r_state <= S_LIT;
                    end else if (!r_pair) begin
                        if (r_fin) begin
                            r_pst   <= ST_ERROR;
                            r_run   <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_hctrl <= r_data;
                            r_sc    <= sc_inc;
                            r_await <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_dist  <= {1'b0, r_data[6:0], r_hext[0]} + 9'd1;
                        r_cnt   <= {1'b0, r_hext[3:1]} + LEN_BIAS;
                        r_sc    <= sc_inc;
                        r_pair  <= 1'b0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (POS_W'(r_dist) > r_wp) begin
                        r_pst   <= ST_ERROR;
                        r_run   <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        // distance of a full ring wraps to the same slot
                        r_src   <= r_wp[AW-1:0] - r_dist[AW-1:0];
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_wp >= i_cfg.cap_limit) begin
                        r_pst   <= ST_ERROR;
                        r_run   <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (can_emit) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {{(TDATA_OUT_W-POS_W-10){1'b0}}, {POS_W{1'b0}},
                                     ST_BYTE, wr_byte};
                        r_olast  <= (r_cnt == 4'd1) && !end_after && !r_fin;
                        r_wp     <= wp_inc;
                        r_src    <= r_src + AW'(1);
                        r_cnt    <= r_cnt - 4'd1;
                        r_state  <= (r_cnt == 4'd1) ? S_POST : S_RD;
                    end
                end
                S_LIT: begin
                    if (can_emit) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {{(TDATA_OUT_W-POS_W-10){1'b0}}, {POS_W{1'b0}},
                                     ST_BYTE, wr_byte};
                        r_olast  <= !end_after && !r_fin;
                        r_wp     <= wp_inc;
                        r_state  <= S_POST;
                    end
                end
                S_POST: begin
                    if (r_wp >= i_cfg.end_pos) begin
                        r_pst   <= ST_FINISH;
                        r_pcnt  <= r_sc;
                        r_run   <= 1'b0;
                        r_state <= S_EMIT;
                    end else if (r_fin) begin
                        r_pst   <= ST_ERROR;
                        r_run   <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (can_emit) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {{(TDATA_OUT_W-POS_W-10){1'b0}},
                                     (r_pst == ST_FINISH) ? r_pcnt : {POS_W{1'b0}},
                                     r_pst, 8'h00};
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
